FILE: rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared constants, the controller state type and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_WIDTH        = 7;
  localparam int WINDOW_RESET     = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic en;
    logic evict;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sws_if.sv
// ----------------------------------------------------------------------------
// Sliding window median channels
// Valid/ready channels for input samples and for median results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sws_sample_if import sws_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           start_sequence;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output start_sequence, output sample, input ready);
  modport sink (input valid, input start_sequence, input sample, output ready);
endinterface

interface sws_result_if import sws_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_WIDTH:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink (input valid, input median_doubled, output ready);
endinterface

`default_nettype wire

FILE: rtl/sws_cell.sv
// ----------------------------------------------------------------------------
// Sorted window cell
// Holds one entry of the sorted window and updates it from its neighbors
// when the oldest sample is removed and the new sample is inserted.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_cell import sws_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire cell_ctl_t                      ctl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] old,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x,
  input  wire logic                           vld_self,
  input  wire logic signed [SAMPLE_WIDTH-1:0] nxt_val,
  input  wire logic                           nxt_vld,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prv_t_val,
  input  wire logic                           prv_t_le,
  output logic signed [SAMPLE_WIDTH-1:0]      val,
  output logic signed [SAMPLE_WIDTH-1:0]      t_val,
  output logic                                t_le
);

  logic                           lt_old;
  logic                           shift_up;
  logic                           t_vld;
  logic signed [SAMPLE_WIDTH-1:0] val_next;

  // After removal, entries at or beyond the evicted one move down by one.
  assign lt_old   = vld_self && (val < old);
  assign shift_up = ctl.evict && !lt_old;
  assign t_val    = shift_up ? nxt_val : val;
  assign t_vld    = shift_up ? nxt_vld : vld_self;
  assign t_le     = t_vld && (t_val <= x);

  always_comb begin
    if (t_le) begin
      val_next = t_val;
    end else if (prv_t_le) begin
      val_next = x;
    end else begin
      val_next = prv_t_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// Sliding window median core
// Running median over the last window_size samples, kept in a sorted row of
// cells, with an arrival ring that names the sample to evict.
// ----------------------------------------------------------------------------
// Usage: samples enter on sample_in (valid/ready); an item is taken when both
// are high. An item with start_sequence set clears the window first. The
// first window_size-1 samples of a sequence give no result; every later
// sample gives one item on median_out, the sum of the two middle values of
// the sorted window (twice the median for an odd window).
// Each item is handled in order: the oldest sample is read from the ring as
// the item is taken, the cell row removes it and inserts the new sample, and
// the middle entries are selected and added. No new item is taken until the
// previous one has finished its sum step and the block is idle again.
// A result is registered; while median_out is stalled the block holds the
// next result in its sum step and takes no new item until it can be stored.
// Writing window_size (cfg_we, cfg_wdata) clears the window; zero acts as one
// and values above MAX_WINDOW act as MAX_WINDOW. Reset clears the window and
// sets window_size to three, or MAX_WINDOW if less; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_core import sws_pkg::*; #(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
  sws_sample_if.sink                sample_in,
  sws_result_if.source              median_out
);

  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  state_t                         state;
  state_t                         state_next;
  logic [WW-1:0]                  win;
  logic [WW-1:0]                  win_cfg;
  logic [WW-1:0]                  fill;
  logic [PW-1:0]                  ptr;
  logic                           emit;
  logic                           out_vld;
  logic signed [SAMPLE_WIDTH:0]   med;
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic                           start_q;
  logic signed [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] ring_q;

  logic                           accept;
  logic                           load_out;
  logic [WW-1:0]                  fill_eff;
  logic [PW-1:0]                  ptr_eff;
  logic                           evict;
  logic [WW:0]                    slot_sum;
  logic [WW:0]                    slot_wrap;
  logic [PW-1:0]                  slot;
  logic [WW:0]                    ptr_inc;
  logic [PW-1:0]                  ptr_upd;
  logic [WW-1:0]                  fill_upd;
  logic [WW-1:0]                  lo_idx;
  logic [WW-1:0]                  hi_idx;
  logic signed [SAMPLE_WIDTH-1:0] lo_val;
  logic signed [SAMPLE_WIDTH-1:0] hi_val;
  logic signed [SAMPLE_WIDTH:0]   sum;
  cell_ctl_t                      ctl;

  logic signed [SAMPLE_WIDTH-1:0] cell_val [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cell_t_val [MAX_WINDOW];
  logic                           cell_t_le [MAX_WINDOW];

  assign accept           = sample_in.valid && sample_in.ready;
  assign sample_in.ready  = (state == ST_IDLE);
  assign median_out.valid = out_vld;
  assign median_out.median_doubled = med;

  always_comb begin
    if (cfg_wdata == '0) begin
      win_cfg = WW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
      win_cfg = WW'(MAX_WINDOW);
    end else begin
      win_cfg = WW'(cfg_wdata);
    end
  end

  assign fill_eff  = start_q ? '0 : fill;
  assign ptr_eff   = start_q ? '0 : ptr;
  assign evict     = (fill_eff == win);
  assign slot_sum  = (WW + 1)'(ptr_eff) + (WW + 1)'(fill_eff);
  assign slot_wrap = (slot_sum >= (WW + 1)'(win)) ? slot_sum - (WW + 1)'(win) : slot_sum;
  assign slot      = evict ? ptr_eff : slot_wrap[PW-1:0];
  assign ptr_inc   = (WW + 1)'(ptr_eff) + (WW + 1)'(1);
  assign fill_upd  = evict ? fill_eff : fill_eff + WW'(1);

  always_comb begin
    if (!evict) begin
      ptr_upd = ptr_eff;
    end else if (ptr_inc >= (WW + 1)'(win)) begin
      ptr_upd = '0;
    end else begin
      ptr_upd = ptr_inc[PW-1:0];
    end
  end

  assign ctl.en    = (state == ST_UPDATE);
  assign ctl.evict = evict;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_row
    logic signed [SAMPLE_WIDTH-1:0] nxt_val;
    logic                           nxt_vld;
    logic signed [SAMPLE_WIDTH-1:0] prv_t_val;
    logic                           prv_t_le;

    if (j == MAX_WINDOW - 1) begin : g_last
      assign nxt_val = '0;
      assign nxt_vld = 1'b0;
    end else begin : g_mid
      assign nxt_val = cell_val[j+1];
      assign nxt_vld = (WW'(j + 1) < fill_eff);
    end

    if (j == 0) begin : g_first
      assign prv_t_val = smp;
      assign prv_t_le  = 1'b1;
    end else begin : g_rest
      assign prv_t_val = cell_t_val[j-1];
      assign prv_t_le  = cell_t_le[j-1];
    end

    sws_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .old       (ring_q),
      .x         (smp),
      .vld_self  (WW'(j) < fill_eff),
      .nxt_val   (nxt_val),
      .nxt_vld   (nxt_vld),
      .prv_t_val (prv_t_val),
      .prv_t_le  (prv_t_le),
      .val       (cell_val[j]),
      .t_val     (cell_t_val[j]),
      .t_le      (cell_t_le[j])
    );
  end

  assign lo_idx = (win - WW'(1)) >> 1;
  assign hi_idx = win >> 1;
  assign lo_val = cell_val[lo_idx[PW-1:0]];
  assign hi_val = cell_val[hi_idx[PW-1:0]];
  assign sum    = $signed({lo_val[SAMPLE_WIDTH-1], lo_val})
                + $signed({hi_val[SAMPLE_WIDTH-1], hi_val});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (sample_in.valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (!emit) begin
          state_next = ST_IDLE;
        end else if (!out_vld || median_out.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= WW'(WIN_RST);
      fill    <= '0;
      ptr     <= '0;
      emit    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        win  <= win_cfg;
        fill <= '0;
        ptr  <= '0;
      end else if (state == ST_UPDATE) begin
        fill <= fill_upd;
        ptr  <= ptr_upd;
      end
      if (state == ST_UPDATE) begin
        emit <= (fill_upd == win);
      end
      if (load_out) begin
        out_vld <= 1'b1;
      end else if (median_out.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp     <= sample_in.sample;
      start_q <= sample_in.start_sequence;
      ring_q  <= ring[ptr];
    end
    if (state == ST_UPDATE) begin
      ring[slot] <= smp;
    end
    if (load_out) begin
      med <= sum;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) fill <= win)
    else $error("window fill exceeds window size");

  assert property (@(posedge clk) disable iff (rst) (WW + 1)'(ptr) < (WW + 1)'(win))
    else $error("oldest pointer outside window");

  assert property (@(posedge clk) disable iff (rst) accept |=> state == ST_UPDATE)
    else $error("accepted item did not start an update");

  assert property (@(posedge clk) disable iff (rst) $rose(out_vld) |-> $past(state == ST_SUM))
    else $error("result appeared outside the sum step");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) && emit |-> lo_val <= hi_val)
    else $error("sorted window out of order at the middle");
`endif

endmodule

`default_nettype wire
